@@ design/rec_pkg.sv @@
package rec_pkg;

  localparam logic KIND_ROTATION = 1'b0;
  localparam logic KIND_BUTTON   = 1'b1;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_DIRECTION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_BUTTON    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_TICKS    = 2'd2;

  localparam logic [15:0] HOLDOFF_RESET = 16'd100;

  localparam logic [1:0] PHASE_LOW  = 2'b00;
  localparam logic [1:0] PHASE_HIGH = 2'b11;

  localparam logic [7:0] POS_MIN = 8'h00;
  localparam logic [7:0] POS_MAX = 8'hff;

  typedef struct packed {
    logic        invert_direction;
    logic        invert_button;
    logic [15:0] holdoff_ticks;
  } cfg_t;

  typedef struct packed {
    logic       channel_a;
    logic       channel_b;
    logic       button_pin;
  } pins_t;

  typedef struct packed {
    logic       report_kind;
    logic       turn_direction;
    logic [7:0] step_amount;
    logic [7:0] current_position;
    logic       button_level;
    logic       last_of_run;
  } report_t;

  typedef struct packed {
    logic    first_valid;
    report_t first;
    logic    second_valid;
    report_t second;
  } report_pair_t;

endpackage

@@ design/rec_tracker.sv @@
module rec_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  rec_pkg::pins_t        pins,
  input  rec_pkg::cfg_t         cfg,
  output rec_pkg::report_pair_t pair
);
  import rec_pkg::*;

  logic [7:0]  position;
  logic [7:0]  reported_position;
  logic [1:0]  last_intermediate_phase;
  logic [1:0]  last_settled_phase;
  logic        reported_button;
  logic [15:0] holdoff_remaining;

  logic [7:0]  position_next;
  logic [7:0]  reported_position_next;
  logic [1:0]  last_intermediate_phase_next;
  logic [1:0]  last_settled_phase_next;
  logic        reported_button_next;
  logic [15:0] holdoff_remaining_next;

  logic [1:0] phase;
  logic       settled;
  logic       move;
  logic       up;
  logic       rot_hit;
  logic       btn_hit;
  logic       cw;
  report_t    rot_report;
  report_t    btn_report;

  always_comb begin
    phase   = {pins.channel_b, pins.channel_a};
    settled = (phase == PHASE_LOW) || (phase == PHASE_HIGH);
    move    = (phase == PHASE_LOW) && (last_settled_phase != PHASE_LOW);
    up      = last_intermediate_phase[0] ^ cfg.invert_direction;

    position_next = position;
    if (move) begin
      position_next = up ? position + 8'd1 : position - 8'd1;
    end
    last_settled_phase_next      = settled ? phase : last_settled_phase;
    last_intermediate_phase_next = settled ? last_intermediate_phase : phase;

    rot_hit = (holdoff_remaining == 16'd0) && (position_next != reported_position);
    cw = ((position_next > reported_position) ||
          ((reported_position == POS_MAX) && (position_next == POS_MIN))) &&
         !((reported_position == POS_MIN) && (position_next == POS_MAX));

    holdoff_remaining_next = holdoff_remaining;
    reported_position_next = reported_position;
    if (holdoff_remaining != 16'd0) begin
      holdoff_remaining_next = holdoff_remaining - 16'd1;
    end else if (rot_hit) begin
      holdoff_remaining_next = cfg.holdoff_ticks;
      reported_position_next = position_next;
    end

    btn_hit              = pins.button_pin != reported_button;
    reported_button_next = pins.button_pin;

    rot_report.report_kind      = KIND_ROTATION;
    rot_report.turn_direction   = cw ? DIR_CW : DIR_CCW;
    rot_report.step_amount      = cw ? position_next - reported_position
                                     : reported_position - position_next;
    rot_report.current_position = position_next;
    rot_report.button_level     = 1'b0;
    rot_report.last_of_run      = !btn_hit;

    btn_report.report_kind      = KIND_BUTTON;
    btn_report.turn_direction   = 1'b0;
    btn_report.step_amount      = 8'd0;
    btn_report.current_position = 8'd0;
    btn_report.button_level     = pins.button_pin ^ cfg.invert_button;
    btn_report.last_of_run      = 1'b1;

    if (rot_hit) begin
      pair.first_valid  = 1'b1;
      pair.first        = rot_report;
      pair.second_valid = btn_hit;
      pair.second       = btn_report;
    end else begin
      pair.first_valid  = btn_hit;
      pair.first        = btn_report;
      pair.second_valid = 1'b0;
      pair.second       = btn_report;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position                <= 8'd0;
      reported_position       <= 8'd0;
      last_intermediate_phase <= 2'd0;
      last_settled_phase      <= 2'd0;
      reported_button         <= 1'b0;
      holdoff_remaining       <= 16'd0;
    end else if (fire) begin
      position                <= position_next;
      reported_position       <= reported_position_next;
      last_intermediate_phase <= last_intermediate_phase_next;
      last_settled_phase      <= last_settled_phase_next;
      reported_button         <= reported_button_next;
      holdoff_remaining       <= holdoff_remaining_next;
    end
  end

`ifndef ASSERT_OFF
  a_holdoff_blocks: assert property (@(posedge clk) disable iff (rst)
    (holdoff_remaining != 16'd0) |-> !(pair.first_valid &&
      pair.first.report_kind == KIND_ROTATION))
    else $error("rotation report during holdoff");

  a_second_is_button: assert property (@(posedge clk) disable iff (rst)
    pair.second_valid |-> (pair.first_valid && pair.second.report_kind == KIND_BUTTON &&
      pair.first.report_kind == KIND_ROTATION))
    else $error("bad report order");

  a_holdoff_starts: assert property (@(posedge clk) disable iff (rst)
    (fire && rot_hit && cfg.holdoff_ticks != 16'd0) |=> (holdoff_remaining != 16'd0))
    else $error("holdoff not started");
`endif

endmodule

@@ design/rec_out_buffer.sv @@
module rec_out_buffer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  rec_pkg::report_pair_t pair,
  output logic                  free,
  output logic                  head_valid,
  output rec_pkg::report_t      head,
  input  logic                  head_ready
);
  import rec_pkg::*;

  logic    v0;
  logic    v1;
  report_t s0;
  report_t s1;

  assign free       = !v0 || (!v1 && head_ready);
  assign head_valid = v0;
  assign head       = s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (load) begin
      v0 <= pair.first_valid;
      v1 <= pair.second_valid;
    end else if (v0 && head_ready) begin
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s0 <= pair.first;
      s1 <= pair.second;
    end else if (v0 && head_ready) begin
      s0 <= s1;
    end
  end

`ifndef ASSERT_OFF
  a_slots_ordered: assert property (@(posedge clk) disable iff (rst)
    v1 |-> v0)
    else $error("second slot filled without first");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (s0.last_of_run == !v1))
    else $error("last flag out of step with slots");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!v1 && (!v0 || head_ready)))
    else $error("load over pending word");
`endif

endmodule

@@ design/rotary_encoder_change_reporter.sv @@
// quadrature encoder decoder with change reports
// s_axis: one word per sample tick, tdata bit 0 channel_a, bit 1 channel_b,
//   bit 2 button_pin; each accepted word is one tick of the decoder
// m_axis: zero, one or two report words per tick, rotation report first;
//   tuser is the report kind (0 rotation, 1 button), tlast marks the
//   final report of a tick
// cfg: one write per handshake, cfg_index selects invert_direction (0),
//   invert_button (1) or holdoff_ticks (2), other indexes are dropped;
//   cfg_ready is always high
// path: the first report of a tick reaches m_axis through the input register,
//   then the two-word result buffer
// throughput: one tick per cycle while each tick yields at most one report
//   and m_axis is ready; a tick with two reports holds the next tick while
//   the result buffer drains
// reset clears position, phases, holdoff and all pending words, and puts
//   the registers back to defaults (holdoff 100 ticks)
// a stalled m_axis holds its word; s_axis takes one more tick into the input
//   register and then stalls until m_axis takes the last pending word
module rotary_encoder_change_reporter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // channel_a, channel_b, button_pin
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [23:0]                        m_axis_tdata,  // turn_direction, step_amount,
                                                            // current_position, button_level
  output logic                               m_axis_tuser,  // report_kind
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rec_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rec_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rec_pkg::*;

  cfg_t         cfg;
  logic         in_valid;
  pins_t        in_pins;
  logic         fire;
  logic         free;
  report_pair_t pair;
  logic         head_valid;
  report_t      head;

  assign cfg_ready     = 1'b1;
  assign fire          = in_valid && free;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_direction <= 1'b0;
      cfg.invert_button    <= 1'b0;
      cfg.holdoff_ticks    <= HOLDOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INVERT_DIRECTION: cfg.invert_direction <= cfg_data[0];
        REG_INVERT_BUTTON:    cfg.invert_button    <= cfg_data[0];
        REG_HOLDOFF_TICKS:    cfg.holdoff_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pins.channel_a  <= s_axis_tdata[0];
      in_pins.channel_b  <= s_axis_tdata[1];
      in_pins.button_pin <= s_axis_tdata[2];
    end
  end

  rec_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .pins (in_pins),
    .cfg  (cfg),
    .pair (pair)
  );

  rec_out_buffer u_out_buffer (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .pair       (pair),
    .free       (free),
    .head_valid (head_valid),
    .head       (head),
    .head_ready (m_axis_tready)
  );

  assign m_axis_tvalid = head_valid;
  assign m_axis_tuser  = head.report_kind;
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tdata  = {6'd0, head.button_level, head.current_position,
                          head.step_amount, head.turn_direction};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] PHASE_A_ONLY = 2'b01;
  localparam logic [1:0] PHASE_B_ONLY = 2'b10;
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_PATTERN = 2;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rotary_encoder_change_reporter dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // decoder copy
  logic cfg_inv_dir = 1'b0;
  logic cfg_inv_btn = 1'b0;
  logic [15:0] cfg_holdoff = HOLDOFF_RESET;
  logic [7:0] enc_pos = '0;
  logic [7:0] reported_pos = '0;
  logic [1:0] hint_phase = '0;
  logic [1:0] settled_phase = '0;
  logic btn_reported = 1'b0;
  logic [15:0] holdoff_left = '0;

  report_t pending_reports[$];
  int unsigned error_count = 0;
  int unsigned tick_count = 0;
  int unsigned burst_left = 0;
  bit eager = 1'b0;
  int unsigned hold_request = 0;
  logic btn_drive = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic predict_tick(input logic [1:0] phase, input logic btn);
    report_t rot;
    report_t press;
    bit have_rot;
    bit have_press;
    logic up;
    logic cw;
    rot = '0;
    press = '0;
    have_rot = 1'b0;
    have_press = 1'b0;
    if (phase == PHASE_LOW || phase == PHASE_HIGH) begin
      if (phase == PHASE_LOW && settled_phase != PHASE_LOW) begin
        up = hint_phase[0] ^ cfg_inv_dir;
        enc_pos = up ? enc_pos + 8'd1 : enc_pos - 8'd1;
      end
      settled_phase = phase;
    end else begin
      hint_phase = phase;
    end
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 16'd1;
    end else if (enc_pos != reported_pos) begin
      cw = (enc_pos > reported_pos || (reported_pos == POS_MAX && enc_pos == POS_MIN)) &&
           !(reported_pos == POS_MIN && enc_pos == POS_MAX);
      rot.report_kind = KIND_ROTATION;
      rot.turn_direction = cw ? DIR_CW : DIR_CCW;
      rot.step_amount = cw ? enc_pos - reported_pos : reported_pos - enc_pos;
      rot.current_position = enc_pos;
      have_rot = 1'b1;
      holdoff_left = cfg_holdoff;
      reported_pos = enc_pos;
    end
    if (btn != btn_reported) begin
      btn_reported = btn;
      press.report_kind = KIND_BUTTON;
      press.button_level = btn ^ cfg_inv_btn;
      have_press = 1'b1;
    end
    if (have_press) press.last_of_run = 1'b1;
    else if (have_rot) rot.last_of_run = 1'b1;
    if (have_rot) pending_reports.push_back(rot);
    if (have_press) pending_reports.push_back(press);
  endtask

  task automatic send_tick(input logic [1:0] phase, input logic btn);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tdata <= {5'b0, btn, phase};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_tick(phase, btn);
    burst_left--;
    tick_count++;
  endtask

  task automatic send_phase(input logic [1:0] phase, input int unsigned max_dwell);
    int unsigned reps;
    reps = $urandom_range(1, max_dwell);
    repeat (reps) begin
      if ($urandom_range(0, 11) == 0) btn_drive = ~btn_drive;
      send_tick(phase, btn_drive);
    end
  endtask

  task automatic send_detent(input bit up, input int unsigned max_dwell);
    send_phase(up ? PHASE_B_ONLY : PHASE_A_ONLY, max_dwell);
    send_phase(PHASE_HIGH, max_dwell);
    send_phase(up ? PHASE_A_ONLY : PHASE_B_ONLY, max_dwell);
    send_phase(PHASE_LOW, max_dwell);
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned up_pct,
                            input int unsigned max_dwell);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = tick_count + n_items;
    while (tick_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_detent($urandom_range(0, 99) < up_pct, max_dwell);
      end else if (pick < 92) begin
        send_phase($urandom_range(0, 1) ? PHASE_A_ONLY : PHASE_B_ONLY, max_dwell);
        send_phase($urandom_range(0, 1) ? PHASE_LOW : PHASE_HIGH, max_dwell);
      end else begin
        send_phase(2'($urandom_range(0, 3)), max_dwell);
      end
    end
  endtask

  task automatic run_out_holdoff();
    while (holdoff_left != 0) send_tick(PHASE_LOW, btn_drive);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INVERT_DIRECTION: cfg_inv_dir = value[0];
      REG_INVERT_BUTTON: cfg_inv_btn = value[0];
      REG_HOLDOFF_TICKS: cfg_holdoff = value[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic inv_dir, input logic inv_btn, input logic [15:0] holdoff);
    wait_idle();
    write_reg(REG_INVERT_DIRECTION, {15'b0, inv_dir});
    write_reg(REG_INVERT_BUTTON, {15'b0, inv_btn});
    write_reg(REG_HOLDOFF_TICKS, holdoff);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_error(input string what, input int unsigned want, input int unsigned got);
    error_count++;
    if (error_count <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_report(input report_t want, input report_t got);
    if (got.report_kind != want.report_kind)
      note_error("report_kind", want.report_kind, got.report_kind);
    if (got.turn_direction != want.turn_direction)
      note_error("turn_direction", want.turn_direction, got.turn_direction);
    if (got.step_amount != want.step_amount)
      note_error("step_amount", want.step_amount, got.step_amount);
    if (got.current_position != want.current_position)
      note_error("current_position", want.current_position, got.current_position);
    if (got.button_level != want.button_level)
      note_error("button_level", want.button_level, got.button_level);
    if (got.last_of_run != want.last_of_run)
      note_error("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  initial begin
    report_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.report_kind = m_axis_tuser;
        got.turn_direction = m_axis_tdata[0];
        got.step_amount = m_axis_tdata[8:1];
        got.current_position = m_axis_tdata[16:9];
        got.button_level = m_axis_tdata[17];
        got.last_of_run = m_axis_tlast;
        if (pending_reports.size() == 0) note_error("word with nothing pending", 0, m_axis_tdata);
        else check_report(pending_reports.pop_front(), got);
      end
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int mode;
    logic [7:0] pattern;
    logic ready_next;
    hold_left = 0;
    mode_left = 0;
    mode = RX_ALWAYS;
    pattern = 8'hff;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
        mode_left = $urandom_range(32, 200);
        pattern = 8'($urandom_range(1, 255));
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: ready_next = 1'b1;
        RX_RANDOM: ready_next = $urandom_range(0, 2) != 0;
        default: ready_next = pattern[mode_left % 8];
      endcase
      if (hold_left != 0) begin
        ready_next = 1'b0;
        hold_left--;
      end
      m_axis_tready <= ready_next;
    end
  end

  task automatic test_reset_state();
    send_tick(PHASE_HIGH, 1'b0);
    send_tick(PHASE_LOW, 1'b0);
    send_tick(PHASE_LOW, 1'b1);
    send_tick(PHASE_LOW, 1'b0);
    run_out_holdoff();
  endtask

  task automatic test_register_writes();
    wait_idle();
    write_reg(REG_UNUSED, 16'hffff);
    write_reg(REG_INVERT_DIRECTION, 16'hfffe);
    write_reg(REG_INVERT_BUTTON, 16'h0003);
    write_reg(REG_HOLDOFF_TICKS, 16'h0000);
    cfg_valid <= 1'b0;
    send_tick(PHASE_B_ONLY, 1'b0);
    send_tick(PHASE_HIGH, 1'b0);
    send_tick(PHASE_A_ONLY, 1'b0);
    send_tick(PHASE_LOW, 1'b1);
    send_tick(PHASE_A_ONLY, 1'b1);
    send_tick(PHASE_HIGH, 1'b1);
    send_tick(PHASE_B_ONLY, 1'b1);
    send_tick(PHASE_LOW, 1'b1);
  endtask

  task automatic test_holdoff_and_inversion();
    wait_idle();
    write_reg(REG_INVERT_DIRECTION, 16'h0001);
    write_reg(REG_HOLDOFF_TICKS, 16'h0002);
    cfg_valid <= 1'b0;
    repeat (2) begin
      send_tick(PHASE_A_ONLY, 1'b1);
      send_tick(PHASE_HIGH, 1'b1);
      send_tick(PHASE_B_ONLY, 1'b1);
      send_tick(PHASE_LOW, 1'b1);
    end
    send_tick(PHASE_A_ONLY, 1'b1);
    send_tick(PHASE_LOW, 1'b1);
    send_tick(PHASE_B_ONLY, 1'b1);
    send_tick(PHASE_HIGH, 1'b0);
    send_tick(PHASE_A_ONLY, 1'b0);
    send_tick(PHASE_LOW, 1'b0);
    btn_drive = 1'b0;
  endtask

  task automatic test_random_mixed();
    configure(1'b0, 1'b0, 16'd0);
    run_random(120, 50, 4);
  endtask

  task automatic test_backpressure();
    configure(1'b1, 1'b1, 16'($urandom_range(1, 8)));
    run_random(60, 50, 3);
    eager = 1'b1;
    hold_request = 300;
    run_random(60, 50, 1);
    eager = 1'b0;
    wait_idle();
    run_random(60, 50, 3);
  endtask

  task automatic test_large_steps();
    configure(1'b0, 1'b1, 16'd560);
    run_random(620, 95, 1);
  endtask

  task automatic test_holdoff_max();
    configure(1'b1, 1'b0, 16'hffff);
    run_out_holdoff();
    run_random(150, 30, 2);
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_writes();
    test_holdoff_and_inversion();
    test_random_mixed();
    test_backpressure();
    test_large_steps();
    test_holdoff_max();
    wait_idle();
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
